[rtl/core/owb_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// owb_pkg
// Types, codes and constants shared by the 1-Wire bus master files.
// ---------------------------------------------------------------------------
package owb_pkg;

    localparam int unsigned TIME_W = 10;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_RST_LOW    = 4'd1,
        PH_RST_WAIT   = 4'd2,
        PH_RST_FINISH = 4'd3,
        PH_W_LOW      = 4'd4,
        PH_W_HIGH     = 4'd5,
        PH_R_LOW      = 4'd6,
        PH_R_WAIT     = 4'd7,
        PH_R_RECOVER  = 4'd8
    } owb_phase_t;

    typedef enum logic [1:0] {
        ACT_RESET = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_ROM   = 2'd3
    } owb_action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW       = 3'd0,
        CFG_PRESENCE_WAIT   = 3'd1,
        CFG_PRESENCE_FINISH = 3'd2,
        CFG_SHORT_LOW       = 3'd3,
        CFG_SLOT            = 3'd4,
        CFG_READ_SAMPLE     = 3'd5,
        CFG_READ_RECOVER    = 3'd6
    } owb_cfg_idx_t;

    localparam logic [TIME_W-1:0] RST_RESET_LOW       = 10'd500;
    localparam logic [TIME_W-1:0] RST_PRESENCE_WAIT   = 10'd100;
    localparam logic [TIME_W-1:0] RST_PRESENCE_FINISH = 10'd150;
    localparam logic [TIME_W-1:0] RST_SHORT_LOW       = 10'd8;
    localparam logic [TIME_W-1:0] RST_SLOT            = 10'd100;
    localparam logic [TIME_W-1:0] RST_READ_SAMPLE     = 10'd20;
    localparam logic [TIME_W-1:0] RST_READ_RECOVER    = 10'd60;

    localparam logic [7:0] ROM_CMD = 8'h33;
    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic [TIME_W-1:0] reset_low_time;
        logic [TIME_W-1:0] presence_wait_time;
        logic [TIME_W-1:0] presence_finish_time;
        logic [TIME_W-1:0] short_low_time;
        logic [TIME_W-1:0] slot_time;
        logic [TIME_W-1:0] read_sample_time;
        logic [TIME_W-1:0] read_recover_time;
    } owb_cfg_t;

    typedef struct packed {
        logic        command_valid;
        owb_action_t action;
        logic [7:0]  write_value;
        logic        line_level;
    } owb_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_value;
        logic       byte_valid;
        logic       byte_last;
    } owb_res_t;

endpackage
`default_nettype wire

[rtl/core/owb_req_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// owb_req_if
// Tick request channel: command fields and sampled line level.
// ---------------------------------------------------------------------------
interface owb_req_if;
    logic       valid;
    logic       ready;
    logic       command_valid;
    logic [1:0] action;
    logic [7:0] write_value;
    logic       line_level;

    modport source (output valid, command_valid, action, write_value, line_level,
                    input ready);
    modport sink (input valid, command_valid, action, write_value, line_level,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/owb_rsp_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// owb_rsp_if
// Tick result channel: bus drive, status flags and read byte.
// ---------------------------------------------------------------------------
interface owb_rsp_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_value;
    logic       byte_valid;
    logic       byte_last;

    modport source (output valid, drive_low, busy_res, done_res, presence,
                    read_value, byte_valid, byte_last, input ready);
    modport sink (input valid, drive_low, busy_res, done_res, presence,
                  read_value, byte_valid, byte_last, output ready);
endinterface
`default_nettype wire

[rtl/core/owb_cfg_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// owb_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface owb_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/owb_cfg_regs.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// owb_cfg_regs
// Slot timing register file, written through the configuration channel.
// ---------------------------------------------------------------------------
module owb_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    owb_cfg_if.sink           cfg,
    output owb_pkg::owb_cfg_t regs
);
    import owb_pkg::*;

    owb_cfg_t regs_reg;
    owb_cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (owb_cfg_idx_t'(cfg.index))
                CFG_RESET_LOW:       regs_next.reset_low_time       = cfg.data;
                CFG_PRESENCE_WAIT:   regs_next.presence_wait_time   = cfg.data;
                CFG_PRESENCE_FINISH: regs_next.presence_finish_time = cfg.data;
                CFG_SHORT_LOW:       regs_next.short_low_time       = cfg.data;
                CFG_SLOT:            regs_next.slot_time            = cfg.data;
                CFG_READ_SAMPLE:     regs_next.read_sample_time     = cfg.data;
                CFG_READ_RECOVER:    regs_next.read_recover_time    = cfg.data;
                default:             regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.reset_low_time       <= RST_RESET_LOW;
            regs_reg.presence_wait_time   <= RST_PRESENCE_WAIT;
            regs_reg.presence_finish_time <= RST_PRESENCE_FINISH;
            regs_reg.short_low_time       <= RST_SHORT_LOW;
            regs_reg.slot_time            <= RST_SLOT;
            regs_reg.read_sample_time     <= RST_READ_SAMPLE;
            regs_reg.read_recover_time    <= RST_READ_RECOVER;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/owb_step.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// owb_step
// Bus sequencer: phase state, tick counter, bit shifter and ROM stepping,
// advanced by one tick on every accepted request.
// ---------------------------------------------------------------------------
module owb_step #(
    parameter int ROM_BYTES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  owb_pkg::owb_item_t item,
    input  owb_pkg::owb_cfg_t  regs,
    output owb_pkg::owb_res_t  result
);
    import owb_pkg::*;

    localparam logic [3:0] ROM_COUNT = 4'(ROM_BYTES);

    owb_phase_t        phase_reg,    phase_next;
    logic [TIME_W-1:0] tick_reg,     tick_next;
    logic [2:0]        bit_reg,      bit_next;
    logic [7:0]        shift_reg,    shift_next;
    logic [2:0]        rom_idx_reg,  rom_idx_next;
    logic [1:0]        rom_step_reg, rom_step_next;
    logic              pres_reg,     pres_next;
    owb_action_t       act_reg,      act_next;

    owb_phase_t        cur_phase;
    logic [TIME_W-1:0] cur_tick;
    logic [2:0]        cur_bit;
    logic [7:0]        cur_shift;
    logic [2:0]        cur_rom_idx;
    logic [1:0]        cur_rom_step;
    owb_action_t       cur_act;

    logic [TIME_W-1:0] dur_raw;
    logic [TIME_W-1:0] dur;
    logic [TIME_W:0]   tick_inc;
    logic              phase_end;
    logic              last_bit;
    logic              last_rom;
    logic              rom_go;
    logic              is_rom;
    logic [7:0]        read_shift;

    // command entry on an idle tick
    always_comb
    begin
        cur_phase    = phase_reg;
        cur_tick     = tick_reg;
        cur_bit      = bit_reg;
        cur_shift    = shift_reg;
        cur_rom_idx  = rom_idx_reg;
        cur_rom_step = rom_step_reg;
        cur_act      = act_reg;
        if (phase_reg == PH_IDLE && item.command_valid)
        begin
            cur_act      = item.action;
            cur_rom_step = 2'd0;
            cur_rom_idx  = 3'd0;
            cur_tick     = '0;
            case (item.action)
                ACT_WRITE:
                begin
                    cur_shift = item.write_value;
                    cur_bit   = 3'd0;
                    cur_phase = PH_W_LOW;
                end
                ACT_READ:
                begin
                    cur_shift = 8'd0;
                    cur_bit   = 3'd0;
                    cur_phase = PH_R_LOW;
                end
                default:
                begin
                    cur_phase = PH_RST_LOW;
                end
            endcase
        end
    end

    always_comb
    begin
        case (cur_phase)
            PH_RST_LOW:    dur_raw = regs.reset_low_time;
            PH_RST_WAIT:   dur_raw = regs.presence_wait_time;
            PH_RST_FINISH: dur_raw = regs.presence_finish_time;
            PH_W_LOW:      dur_raw = cur_shift[0] ? regs.short_low_time : regs.slot_time;
            PH_W_HIGH:     dur_raw = cur_shift[0] ? regs.slot_time : TIME_W'(1);
            PH_R_LOW:      dur_raw = regs.short_low_time;
            PH_R_WAIT:     dur_raw = regs.read_sample_time;
            default:       dur_raw = regs.read_recover_time;
        endcase
    end

    assign dur        = (dur_raw == '0) ? TIME_W'(1) : dur_raw;
    assign tick_inc   = {1'b0, cur_tick} + (TIME_W+1)'(1);
    assign phase_end  = (cur_phase != PH_IDLE) && (tick_inc >= {1'b0, dur});
    assign last_bit   = (cur_bit == LAST_BIT);
    assign is_rom     = (cur_act == ACT_ROM);
    assign last_rom   = (({1'b0, cur_rom_idx} + 4'd1) >= ROM_COUNT);
    assign rom_go     = is_rom && (cur_rom_step == 2'd0) && pres_reg;
    assign read_shift = {item.line_level, cur_shift[7:1]};

    // next state
    always_comb
    begin
        phase_next    = cur_phase;
        tick_next     = cur_tick;
        bit_next      = cur_bit;
        shift_next    = cur_shift;
        rom_idx_next  = cur_rom_idx;
        rom_step_next = cur_rom_step;
        pres_next     = pres_reg;
        act_next      = cur_act;
        if (cur_phase != PH_IDLE)
        begin
            if (!phase_end)
            begin
                tick_next = tick_inc[TIME_W-1:0];
            end
            else
            begin
                tick_next = '0;
                case (cur_phase)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                    end
                    PH_RST_WAIT:
                    begin
                        pres_next  = !item.line_level;
                        phase_next = PH_RST_FINISH;
                    end
                    PH_RST_FINISH:
                    begin
                        if (rom_go)
                        begin
                            rom_step_next = 2'd1;
                            shift_next    = ROM_CMD;
                            bit_next      = 3'd0;
                            phase_next    = PH_W_LOW;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_W_LOW:
                    begin
                        phase_next = PH_W_HIGH;
                    end
                    PH_W_HIGH:
                    begin
                        shift_next = {1'b0, cur_shift[7:1]};
                        if (last_bit)
                        begin
                            if (is_rom)
                            begin
                                rom_step_next = 2'd2;
                                rom_idx_next  = 3'd0;
                                shift_next    = 8'd0;
                                bit_next      = 3'd0;
                                phase_next    = PH_R_LOW;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        else
                        begin
                            bit_next   = cur_bit + 3'd1;
                            phase_next = PH_W_LOW;
                        end
                    end
                    PH_R_LOW:
                    begin
                        phase_next = PH_R_WAIT;
                    end
                    PH_R_WAIT:
                    begin
                        shift_next = read_shift;
                        phase_next = PH_R_RECOVER;
                    end
                    PH_R_RECOVER:
                    begin
                        if (last_bit)
                        begin
                            if (is_rom)
                            begin
                                if (last_rom)
                                begin
                                    rom_step_next = 2'd3;
                                    phase_next    = PH_RST_LOW;
                                end
                                else
                                begin
                                    rom_idx_next = cur_rom_idx + 3'd1;
                                    shift_next   = 8'd0;
                                    bit_next     = 3'd0;
                                    phase_next   = PH_R_LOW;
                                end
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        else
                        begin
                            bit_next   = cur_bit + 3'd1;
                            phase_next = PH_R_LOW;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // outputs
    always_comb
    begin
        result            = '0;
        result.busy_res   = (cur_phase != PH_IDLE);
        result.drive_low  = (cur_phase == PH_RST_LOW) || (cur_phase == PH_W_LOW)
                         || (cur_phase == PH_R_LOW);
        result.presence   = pres_next;
        if (phase_end)
        begin
            case (cur_phase)
                PH_RST_FINISH:
                begin
                    result.done_res = !rom_go;
                end
                PH_W_HIGH, PH_R_RECOVER:
                begin
                    result.done_res = last_bit && !is_rom;
                end
                PH_R_WAIT:
                begin
                    if (last_bit)
                    begin
                        result.byte_valid = 1'b1;
                        result.read_value = read_shift;
                        result.byte_last  = !is_rom || last_rom;
                    end
                end
                default:
                begin
                    result.done_res = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            rom_idx_reg  <= '0;
            rom_step_reg <= '0;
            pres_reg     <= 1'b0;
            act_reg      <= ACT_RESET;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            rom_idx_reg  <= rom_idx_next;
            rom_step_reg <= rom_step_next;
            pres_reg     <= pres_next;
            act_reg      <= act_next;
        end
    end

`ifndef SYNTHESIS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.done_res |-> result.busy_res)
        else $error("done without busy");
    a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.byte_valid |-> (result.busy_res && !result.drive_low))
        else $error("read byte outside a released read phase");
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_IDLE && !item.command_valid) |=> phase_reg == PH_IDLE)
        else $error("left idle without a command");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.done_res) |=> phase_reg == PH_IDLE)
        else $error("not idle after done");
`endif

endmodule
`default_nettype wire

[rtl/core/owb_out_queue.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// owb_out_queue
// Two-entry result buffer between the sequencer and the result channel.
// ---------------------------------------------------------------------------
module owb_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  owb_pkg::owb_res_t push_data,
    output logic              push_ready,
    owb_rsp_if.source         rsp
);
    import owb_pkg::*;

    logic     valid0_reg, valid0_next;
    logic     valid1_reg, valid1_next;
    owb_res_t data0_reg,  data0_next;
    owb_res_t data1_reg,  data1_next;
    logic     pop;

    assign push_ready = !valid1_reg;
    assign pop        = valid0_reg && rsp.ready;

    assign rsp.valid      = valid0_reg;
    assign rsp.drive_low  = data0_reg.drive_low;
    assign rsp.busy_res   = data0_reg.busy_res;
    assign rsp.done_res   = data0_reg.done_res;
    assign rsp.presence   = data0_reg.presence;
    assign rsp.read_value = data0_reg.read_value;
    assign rsp.byte_valid = data0_reg.byte_valid;
    assign rsp.byte_last  = data0_reg.byte_last;

    always_comb
    begin
        valid0_next = valid0_reg;
        valid1_next = valid1_reg;
        data0_next  = data0_reg;
        data1_next  = data1_reg;
        if (pop)
        begin
            valid0_next = valid1_reg;
            valid1_next = 1'b0;
            data0_next  = data1_reg;
        end
        if (push)
        begin
            if (!valid0_next)
            begin
                valid0_next = 1'b1;
                data0_next  = push_data;
            end
            else
            begin
                valid1_next = 1'b1;
                data1_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
        end
        else
        begin
            valid0_reg <= valid0_next;
            valid1_reg <= valid1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data0_reg <= data0_next;
        data1_reg <= data1_next;
    end

`ifndef SYNTHESIS
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        valid1_reg |-> valid0_reg)
        else $error("second entry held without a head entry");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (valid1_reg && !pop) |=> valid1_reg && $stable(data1_reg))
        else $error("second entry lost while stalled");
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !valid0_reg) |=> (valid0_reg && data0_reg == $past(push_data)))
        else $error("request result not loaded into empty buffer");
`endif

endmodule
`default_nettype wire

[rtl/core/one_wire_bus_master.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master stepped by one tick per accepted request: reset with
// presence detect, byte write, byte read and read ROM, with timing registers.
// ---------------------------------------------------------------------------
// The result is registered in the result buffer; while that buffer has room,
// throughput is one request per clock; the sequencer state advances in one pass.
// A two-entry result buffer keeps req ready while one result waits on rsp.
// Reset: rst_n clears the sequencer to idle, empties the result buffer and
// loads the timing registers with their defaults; no clearing pass follows.
// ---------------------------------------------------------------------------
module one_wire_bus_master #(
    parameter int ROM_BYTES = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    owb_req_if.sink   req,
    owb_rsp_if.source rsp,
    owb_cfg_if.sink   cfg
);
    import owb_pkg::*;

    owb_cfg_t  regs;
    owb_item_t item;
    owb_res_t  result;
    logic      accept;
    logic      push_ready;

    assign item.command_valid = req.command_valid;
    assign item.action        = owb_action_t'(req.action);
    assign item.write_value   = req.write_value;
    assign item.line_level    = req.line_level;

    assign req.ready = push_ready;
    assign accept    = req.valid && push_ready;

    owb_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    owb_step #(
        .ROM_BYTES (ROM_BYTES)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .regs   (regs),
        .result (result)
    );

    owb_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (result),
        .push_ready (push_ready),
        .rsp        (rsp)
    );

endmodule
`default_nettype wire

[tb/owb_tick_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// owb_tick_checker
// Watches the request, result and configuration channels of the 1-Wire bus
// master, predicts the output of every accepted tick request with its own
// sequencer model and compares each accepted result, field by field, with
// the oldest prediction.
// ---------------------------------------------------------------------------
module owb_tick_checker #(
    parameter int ROM_BYTES = 8
) (
    input  logic clk,
    input  logic rst_n,
    owb_req_if   req,
    owb_rsp_if   rsp,
    owb_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);
    import owb_pkg::*;

    logic [TIME_W-1:0] time_reg [7];
    owb_phase_t        seq_phase;
    logic [TIME_W-1:0] tick_cnt;
    logic [2:0]        bit_idx;
    logic [7:0]        shift_reg;
    logic [2:0]        rom_idx;
    logic [1:0]        rom_stage;
    logic              pres_flag;
    owb_action_t       cur_act;
    owb_res_t          predicted_ticks [$];

    function automatic void go(input owb_phase_t p);
        seq_phase = p;
        tick_cnt = '0;
    endfunction

    function automatic void begin_write(input logic [7:0] v);
        shift_reg = v;
        bit_idx = '0;
        go(PH_W_LOW);
    endfunction

    function automatic void begin_read();
        shift_reg = '0;
        bit_idx = '0;
        go(PH_R_LOW);
    endfunction

    function automatic logic [TIME_W-1:0] phase_len();
        logic [TIME_W-1:0] len;
        case (seq_phase)
            PH_RST_LOW:    len = time_reg[CFG_RESET_LOW];
            PH_RST_WAIT:   len = time_reg[CFG_PRESENCE_WAIT];
            PH_RST_FINISH: len = time_reg[CFG_PRESENCE_FINISH];
            PH_W_LOW:      len = shift_reg[0] ? time_reg[CFG_SHORT_LOW] : time_reg[CFG_SLOT];
            PH_W_HIGH:     len = shift_reg[0] ? time_reg[CFG_SLOT] : TIME_W'(1);
            PH_R_LOW:      len = time_reg[CFG_SHORT_LOW];
            PH_R_WAIT:     len = time_reg[CFG_READ_SAMPLE];
            default:       len = time_reg[CFG_READ_RECOVER];
        endcase
        return (len == '0) ? TIME_W'(1) : len;
    endfunction

    function automatic owb_res_t bus_tick(input logic cmd, input logic [1:0] act,
                                          input logic [7:0] wv, input logic line);
        owb_res_t          r;
        logic [TIME_W:0]   nxt;
        r = '0;
        if (seq_phase == PH_IDLE && cmd) begin
            cur_act = owb_action_t'(act);
            rom_stage = '0;
            rom_idx = '0;
            if (cur_act == ACT_WRITE)
                begin_write(wv);
            else if (cur_act == ACT_READ)
                begin_read();
            else
                go(PH_RST_LOW);
        end
        if (seq_phase != PH_IDLE) begin
            r.busy_res = 1'b1;
            r.drive_low = (seq_phase == PH_RST_LOW) || (seq_phase == PH_W_LOW) ||
                          (seq_phase == PH_R_LOW);
            nxt = {1'b0, tick_cnt} + 1'b1;
            if (nxt < {1'b0, phase_len()}) begin
                tick_cnt = nxt[TIME_W-1:0];
            end else begin
                case (seq_phase)
                    PH_RST_LOW: go(PH_RST_WAIT);
                    PH_RST_WAIT:
                    begin
                        pres_flag = !line;
                        go(PH_RST_FINISH);
                    end
                    PH_RST_FINISH:
                    begin
                        if (cur_act == ACT_ROM && rom_stage == 2'd0 && pres_flag) begin
                            rom_stage = 2'd1;
                            begin_write(ROM_CMD);
                        end else begin
                            r.done_res = 1'b1;
                            go(PH_IDLE);
                        end
                    end
                    PH_W_LOW: go(PH_W_HIGH);
                    PH_W_HIGH:
                    begin
                        shift_reg = shift_reg >> 1;
                        if (bit_idx == LAST_BIT) begin
                            if (cur_act == ACT_ROM) begin
                                rom_stage = 2'd2;
                                rom_idx = '0;
                                begin_read();
                            end else begin
                                r.done_res = 1'b1;
                                go(PH_IDLE);
                            end
                        end else begin
                            bit_idx++;
                            go(PH_W_LOW);
                        end
                    end
                    PH_R_LOW: go(PH_R_WAIT);
                    PH_R_WAIT:
                    begin
                        shift_reg = {line, shift_reg[7:1]};
                        if (bit_idx == LAST_BIT) begin
                            r.byte_valid = 1'b1;
                            r.read_value = shift_reg;
                            r.byte_last = (cur_act != ACT_ROM) ||
                                          (int'(rom_idx) + 1 >= ROM_BYTES);
                        end
                        go(PH_R_RECOVER);
                    end
                    default:
                    begin
                        if (bit_idx == LAST_BIT) begin
                            if (cur_act == ACT_ROM) begin
                                if (int'(rom_idx) + 1 >= ROM_BYTES) begin
                                    rom_stage = 2'd3;
                                    go(PH_RST_LOW);
                                end else begin
                                    rom_idx++;
                                    begin_read();
                                end
                            end else begin
                                r.done_res = 1'b1;
                                go(PH_IDLE);
                            end
                        end else begin
                            bit_idx++;
                            go(PH_R_LOW);
                        end
                    end
                endcase
            end
        end
        r.presence = pres_flag;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        owb_res_t got;
        owb_res_t want;
        if (!rst_n) begin
            time_reg[CFG_RESET_LOW]       = RST_RESET_LOW;
            time_reg[CFG_PRESENCE_WAIT]   = RST_PRESENCE_WAIT;
            time_reg[CFG_PRESENCE_FINISH] = RST_PRESENCE_FINISH;
            time_reg[CFG_SHORT_LOW]       = RST_SHORT_LOW;
            time_reg[CFG_SLOT]            = RST_SLOT;
            time_reg[CFG_READ_SAMPLE]     = RST_READ_SAMPLE;
            time_reg[CFG_READ_RECOVER]    = RST_READ_RECOVER;
            seq_phase = PH_IDLE;
            tick_cnt = '0;
            bit_idx = '0;
            shift_reg = '0;
            rom_idx = '0;
            rom_stage = '0;
            pres_flag = 1'b0;
            cur_act = ACT_RESET;
            predicted_ticks.delete();
            mismatches = 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                got.drive_low  = rsp.drive_low;
                got.busy_res   = rsp.busy_res;
                got.done_res   = rsp.done_res;
                got.presence   = rsp.presence;
                got.read_value = rsp.read_value;
                got.byte_valid = rsp.byte_valid;
                got.byte_last  = rsp.byte_last;
                if (predicted_ticks.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with no request outstanding", $time);
                    mismatches++;
                end else begin
                    want = predicted_ticks.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display({"%0t: tick mismatch, expected drive %b busy %b done %b ",
                                      "presence %b byte %h valid %b last %b, got drive %b ",
                                      "busy %b done %b presence %b byte %h valid %b last %b"},
                                     $time, want.drive_low, want.busy_res, want.done_res,
                                     want.presence, want.read_value, want.byte_valid,
                                     want.byte_last, got.drive_low, got.busy_res,
                                     got.done_res, got.presence, got.read_value,
                                     got.byte_valid, got.byte_last);
                        mismatches++;
                    end
                end
            end
            if (cfg.valid && cfg.ready && cfg.index <= CFG_READ_RECOVER)
                time_reg[cfg.index] = cfg.data;
            if (req.valid && req.ready)
                predicted_ticks.push_back(bus_tick(req.command_valid, req.action,
                                                   req.write_value, req.line_level));
        end
        outstanding = predicted_ticks.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench top for the 1-Wire bus master: drives tick requests and timing
// register writes with random gaps and result stalls, runs directed commands
// then randomized phases under several timing settings, and reports the
// verdict from the checker's mismatch and outstanding counts.
// ---------------------------------------------------------------------------
module tb;
    import owb_pkg::*;

    localparam int ROM_BYTES   = 8;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RAND_PHASES = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam int TIMING_MAX   = 0;
    localparam int TIMING_ZERO  = 1;
    localparam int TIMING_ONE   = 2;
    localparam int TIMING_MIXED = 3;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   idle_cycles = 0;

    owb_req_if req_ch ();
    owb_rsp_if rsp_ch ();
    owb_cfg_if cfg_ch ();

    one_wire_bus_master #(
        .ROM_BYTES(ROM_BYTES)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch),
        .cfg  (cfg_ch)
    );

    owb_tick_checker #(
        .ROM_BYTES(ROM_BYTES)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 8)
            return 0;
        if (pick < 13)
            return $urandom_range(1, 3);
        if (pick < 15)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TIME_W-1:0] timing_value(input int kind);
        int pick;
        pick = $urandom_range(0, 31);
        case (kind)
            TIMING_MAX:  return '1;
            TIMING_ZERO: return '0;
            TIMING_ONE:  return TIME_W'(1);
            default:
            begin
                if (pick == 0)
                    return '1;
                if (pick < 4)
                    return '0;
                if (pick < 24)
                    return TIME_W'($urandom_range(1, 3));
                return TIME_W'($urandom_range(4, 15));
            end
        endcase
    endfunction

    task automatic drive_tick(input logic cmd, input logic [1:0] act, input logic [7:0] wv,
                              input logic line);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.command_valid = cmd;
        req_ch.action = act;
        req_ch.write_value = wv;
        req_ch.line_level = line;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // first tick carries the command, later ticks offer commands the busy master drops
    task automatic issue(input owb_action_t act, input logic [7:0] wv, input logic line,
                         input int n_fixed, input int n_ticks);
        drive_tick(1'b1, act, wv, line);
        for (int i = 1; i < n_ticks; i++)
            drive_tick(1'($urandom_range(0, 1)), 2'($urandom), 8'($urandom),
                       (i < n_fixed) ? line : 1'($urandom));
    endtask

    task automatic random_tick();
        drive_tick($urandom_range(0, 3) == 0, 2'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic settle();
        req_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_timing(input int kind);
        settle();
        for (int i = 0; i <= int'(CFG_READ_RECOVER); i++)
            write_reg(CFG_IDX_W'(i), timing_value(kind));
        write_reg(CFG_SPARE, TIME_W'($urandom));
        cfg_ch.valid = 1'b0;
    endtask

    initial
    begin
        int run;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            rsp_ch.ready = 1'b1;
            run = $urandom_range(1, 24);
            repeat (run) @(negedge clk);
            run = gap_len();
            if (run != 0) begin
                rsp_ch.ready = 1'b0;
                repeat (run) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int kind;
        int n_ticks;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command_valid = 1'b0;
        req_ch.action = ACT_RESET;
        req_ch.write_value = 8'h00;
        req_ch.line_level = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_RESET_LOW;
        cfg_ch.data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset pulse at default timing, cut short by the register write
        issue(ACT_RESET, 8'h00, 1'b1, 0, 20);
        load_timing(TIMING_ONE);
        repeat (3) drive_tick(1'b1, ACT_WRITE, 8'hFF, 1'b0);

        issue(ACT_RESET, 8'h00, 1'b1, 3, 3);
        issue(ACT_RESET, 8'h00, 1'b0, 3, 3);
        issue(ACT_WRITE, 8'h00, 1'b1, 0, 16);
        issue(ACT_WRITE, 8'hFF, 1'b0, 0, 16);
        issue(ACT_WRITE, 8'h5A, 1'b1, 0, 16);
        issue(ACT_READ, 8'h00, 1'b1, 24, 24);
        issue(ACT_READ, 8'hFF, 1'b0, 24, 24);
        issue(ACT_ROM, 8'h00, 1'b1, 3, 3);
        issue(ACT_ROM, 8'h00, 1'b0, 3, 214);

        for (int p = 0; p < RAND_PHASES; p++) begin
            kind = (p == 0) ? TIMING_MAX : (p == 1) ? TIMING_ZERO : TIMING_MIXED;
            load_timing(kind);
            n_ticks = (kind == TIMING_MAX) ? 60 : 80;
            repeat (n_ticks) random_tick();
        end

        settle();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
